@@ hw/rtl/mctt_pkg.sv @@
// Shared constants, command codes and control/status types of the
// multi-channel timeout timer. No dependencies.
package mctt_pkg;

  localparam int KIND_W      = 3;
  localparam int CH_W        = 3;
  localparam int PERIOD_W    = 16;
  localparam int CFG_W       = 4;
  localparam int MASK_W      = 8;
  localparam int COUNT_OUT_W = 16;

  localparam int DEFAULT_CHANNELS     = 8;
  localparam int DEFAULT_COUNTER_BITS = 16;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP    = 3'd4;

  typedef struct packed {
    logic exec;   // execute the accepted item
    logic emit;   // present one result, drop its hit
  } ctrl_t;

  typedef struct packed {
    logic last;   // at most one hit left to report
  } stat_t;

endpackage

@@ hw/rtl/mctt_ctrl.sv @@
// Controller of the timeout timer: accepts items and sequences result slots.
// Depends on mctt_pkg.
module mctt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mctt_pkg::stat_t stat,
  output logic            busy,
  output mctt_pkg::ctrl_t ctrl
);

  localparam logic [0:0] IDLE = 1'b0;
  localparam logic [0:0] EMIT = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (start) state_next = EMIT;
      end
      EMIT: begin
        if (stat.last) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy      = (state == EMIT);
  assign ctrl.exec = start && (state == IDLE);
  assign ctrl.emit = (state == EMIT);

endmodule

@@ hw/rtl/mctt_datapath.sv @@
// Datapath of the timeout timer: shared counter, per-channel compare state,
// hit vector walked one result per cycle. Depends on mctt_pkg.
module mctt_datapath #(
  parameter int CHANNELS     = mctt_pkg::DEFAULT_CHANNELS,
  parameter int COUNTER_BITS = mctt_pkg::DEFAULT_COUNTER_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mctt_pkg::ctrl_t                  ctrl,
  output mctt_pkg::stat_t                  stat,
  input  logic [mctt_pkg::KIND_W-1:0]      kind,
  input  logic [mctt_pkg::CH_W-1:0]        channel,
  input  logic [mctt_pkg::PERIOD_W-1:0]    period,
  input  logic                             repeat_req,
  input  logic                             cfg_we,
  input  logic [mctt_pkg::CFG_W-1:0]       cfg_data,
  output logic                             expired_valid,
  output logic [mctt_pkg::CH_W-1:0]        expired_channel,
  output logic                             last,
  output logic [mctt_pkg::MASK_W-1:0]      running_mask,
  output logic [mctt_pkg::MASK_W-1:0]      pending_mask,
  output logic [mctt_pkg::COUNT_OUT_W-1:0] counter_value
);

  logic [mctt_pkg::CFG_W-1:0] active;
  logic [COUNTER_BITS-1:0]    counter;
  logic [COUNTER_BITS-1:0]    counter_inc;
  logic [COUNTER_BITS-1:0]    period_in;
  logic [COUNTER_BITS-1:0]    compare [CHANNELS];
  logic [COUNTER_BITS-1:0]    period_r [CHANNELS];
  logic [CHANNELS-1:0]        repeat_r;
  logic [CHANNELS-1:0]        enabled;
  logic [CHANNELS-1:0]        pending;
  logic [CHANNELS-1:0]        hit;
  logic [CHANNELS-1:0]        hits;
  logic [CHANNELS-1:0]        act;
  logic                       is_tick;

  assign counter_inc = counter + COUNTER_BITS'(1);
  assign period_in   = COUNTER_BITS'(period);
  assign is_tick     = (kind == mctt_pkg::KIND_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= mctt_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (ctrl.exec && is_tick) begin
      counter <= counter_inc;
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
    logic sel;

    assign act[i]  = (active > mctt_pkg::CFG_W'(i));
    assign hits[i] = enabled[i] && act[i] && (compare[i] == counter_inc);
    assign sel     = act[i] && (channel == mctt_pkg::CH_W'(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        compare[i]  <= '0;
        period_r[i] <= '0;
        repeat_r[i] <= 1'b0;
        enabled[i]  <= 1'b0;
        pending[i]  <= 1'b0;
      end else if (ctrl.exec) begin
        if (is_tick) begin
          if (hits[i]) begin
            pending[i] <= 1'b1;
            // compare equals the new counter on a hit, so the reload never
            // falls behind it
            if (repeat_r[i]) compare[i] <= compare[i] + period_r[i];
            else enabled[i] <= 1'b0;
          end
        end else if (sel) begin
          case (kind)
            mctt_pkg::KIND_SET: begin
              period_r[i] <= period_in;
              repeat_r[i] <= repeat_req;
            end
            mctt_pkg::KIND_START: begin
              compare[i] <= counter + period_r[i];
              pending[i] <= 1'b0;
              enabled[i] <= 1'b1;
            end
            mctt_pkg::KIND_RESTART: begin
              compare[i] <= counter + period_r[i];
            end
            mctt_pkg::KIND_STOP: begin
              enabled[i] <= 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= '0;
    end else if (ctrl.exec) begin
      hit <= is_tick ? hits : '0;
    end else if (ctrl.emit) begin
      hit <= hit & (hit - CHANNELS'(1));
    end
  end

  always_comb begin
    expired_channel = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (hit[i]) expired_channel = mctt_pkg::CH_W'(i);
    end
  end

  assign expired_valid = |hit;
  assign last          = ~|(hit & (hit - CHANNELS'(1)));
  assign stat.last     = last;
  assign running_mask  = mctt_pkg::MASK_W'(enabled);
  assign pending_mask  = mctt_pkg::MASK_W'(pending);
  assign counter_value = mctt_pkg::COUNT_OUT_W'(counter);

endmodule

@@ hw/rtl/multi_channel_timeout_timer_core.sv @@
// Top level of the multi-channel timeout timer.
// Depends on mctt_pkg, mctt_ctrl and mctt_datapath.
//
// Usage:
//   Items enter on start/kind/channel/period/repeat_req and are taken at an
//   edge with start high and busy low. Kind tick advances the shared counter
//   and compares every active channel in parallel; the other kinds set,
//   start, restart or stop one active channel; kinds 5 to 7 change no state.
//   Results leave on result_valid, one per cycle, for exactly one cycle each.
//   A tick gives one result per expiring channel in ascending channel order;
//   any other item, or a tick without expiry, gives one status result.
//   last marks the final result of an item. Masks and counter show the state
//   after the whole item.
//   The first result appears in the cycle after acceptance.
//   No new item is taken until the last result of the previous one is out;
//   the single result port walks the registered hit vector one bit a cycle.
//   busy is high while results are being emitted.
//   The receiver cannot stall; results are not held.
//   active_channels is written on cfg_valid/cfg_ready while idle.
//   Reset (rst, synchronous): counter and all channel state cleared,
//   active_channels = 8. No clearing pass.
module multi_channel_timeout_timer_core #(
  parameter int CHANNELS     = mctt_pkg::DEFAULT_CHANNELS,
  parameter int COUNTER_BITS = mctt_pkg::DEFAULT_COUNTER_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [mctt_pkg::KIND_W-1:0]      kind,
  input  logic [mctt_pkg::CH_W-1:0]        channel,
  input  logic [mctt_pkg::PERIOD_W-1:0]    period,
  input  logic                             repeat_req,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mctt_pkg::CFG_W-1:0]       cfg_data,
  output logic                             result_valid,
  output logic                             expired_valid,
  output logic [mctt_pkg::CH_W-1:0]        expired_channel,
  output logic                             last,
  output logic [mctt_pkg::MASK_W-1:0]      running_mask,
  output logic [mctt_pkg::MASK_W-1:0]      pending_mask,
  output logic [mctt_pkg::COUNT_OUT_W-1:0] counter_value
);

  mctt_pkg::ctrl_t ctrl;
  mctt_pkg::stat_t stat;

  assign cfg_ready    = ~busy;
  assign result_valid = ctrl.emit;

  mctt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  mctt_datapath #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .stat            (stat),
    .kind            (kind),
    .channel         (channel),
    .period          (period),
    .repeat_req      (repeat_req),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_data        (cfg_data),
    .expired_valid   (expired_valid),
    .expired_channel (expired_channel),
    .last            (last),
    .running_mask    (running_mask),
    .pending_mask    (pending_mask),
    .counter_value   (counter_value)
  );

endmodule

@@ hw/rtl/mctt_checker.sv @@
// Port-level checks of the timeout timer, bound to the top level.
// Depends on mctt_pkg and multi_channel_timeout_timer_core.
module mctt_port_checks (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             result_valid,
  input logic                             expired_valid,
  input logic [mctt_pkg::CH_W-1:0]        expired_channel,
  input logic                             last,
  input logic [mctt_pkg::COUNT_OUT_W-1:0] counter_value
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> result_valid)
    else $error("accepted item produced no result");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !expired_valid |-> last)
    else $error("status result not marked last");

  a_expiry_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid && expired_valid &&
      (expired_channel > $past(expired_channel)))
    else $error("expiry results out of order or broken");

  a_counter_steady: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> $stable(counter_value))
    else $error("counter moved within one item");

endmodule

bind multi_channel_timeout_timer_core mctt_port_checks u_mctt_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .result_valid    (result_valid),
  .expired_valid   (expired_valid),
  .expired_channel (expired_channel),
  .last            (last),
  .counter_value   (counter_value)
);
